FILE: hw/rtl/interval_group_partitioner_defines.svh
// Assertion macros used by the partitioner module.
`ifndef INTERVAL_GROUP_PARTITIONER_DEFINES_SVH
`define INTERVAL_GROUP_PARTITIONER_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define IGP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define IGP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/igp_pkg.sv
// Package: types and constants of the interval group partitioner.
package igp_pkg;
  localparam int unsigned MaxIntervals = 64;
  localparam int unsigned ValW = 32;
  localparam int unsigned GrpW = 6;
  localparam int unsigned TotW = 7;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_GRP_SCAN,
    ST_GRP_CHK,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD,
    ST_CLEAR
  } state_t;

  // Signed pair ordering: true when (sa,ea) sorts strictly before (sb,eb).
  function automatic logic pair_before(logic [ValW-1:0] sa, logic [ValW-1:0] ea,
                                       logic [ValW-1:0] sb, logic [ValW-1:0] eb);
    if (sa != sb) return $signed(sa) < $signed(sb);
    return $signed(ea) < $signed(eb);
  endfunction
endpackage

FILE: hw/rtl/igp_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module igp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/interval_group_partitioner.sv
// Flow: the set is loaded, sorted by an insertion sort, then split into groups by repeated passes.
// Results then leave one at a time, each held until accepted; no new interval is taken meanwhile.
// The sort does one memory read per step; the group passes then assign each entry a group.
// After emission a clearing pass resets the group marks of all MAX_INTERVALS entries.
// Synchronous active-high rst clears control state; intervals are undefined until written.
// Reset also starts one clearing pass of the mark memory before the first item.
`include "interval_group_partitioner_defines.svh"
module interval_group_partitioner #(
  parameter int unsigned MAX_INTERVALS = igp_pkg::MaxIntervals
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // start_time[31:0], end_time[63:32]
  input  logic        s_axis_tlast,  // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // sorted_start, sorted_end, group_number, group_total, overflowed
  output logic        m_axis_tlast   // last_result
);
  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned VW = igp_pkg::ValW;
  localparam int unsigned GW = igp_pkg::TotW;
  localparam logic [GW-1:0] MarkNone = '1;

  igp_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] i_idx, i_idx_next;   // outer index
  logic [CW-1:0] j_idx, j_idx_next;   // inner index
  logic [VW-1:0] key_s, key_s_next, key_e, key_e_next;  // sort key / latest end
  logic [GW-1:0] groups, groups_next;
  logic          open_grp, open_grp_next;

  // Memory ports
  logic          se_we, mk_we;
  logic [AW-1:0] se_waddr, se_raddr, mk_waddr, mk_raddr;
  logic [2*VW-1:0] se_wdata, se_rdata;
  logic [GW-1:0] mk_wdata, mk_rdata;

  igp_ram #(.Width(2*VW), .Depth(MAX_INTERVALS)) u_pair_ram (
    .clk(clk), .we(se_we), .waddr(se_waddr), .wdata(se_wdata),
    .raddr(se_raddr), .rdata(se_rdata)
  );
  igp_ram #(.Width(GW), .Depth(MAX_INTERVALS)) u_mark_ram (
    .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
    .raddr(mk_raddr), .rdata(mk_rdata)
  );

  logic [VW-1:0] rd_s, rd_e;
  assign rd_s = se_rdata[VW-1:0];
  assign rd_e = se_rdata[2*VW-1:VW];

  // Output register
  logic [2*VW-1:0] o_pair;
  logic [GW-1:0]   o_mark;
  logic            o_load;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= igp_pkg::ST_CLEAR;
      count <= '0; ovf <= 1'b0; i_idx <= '0; j_idx <= '0;
      groups <= '0; open_grp <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next; ovf <= ovf_next; i_idx <= i_idx_next; j_idx <= j_idx_next;
      groups <= groups_next; open_grp <= open_grp_next;
    end
  end

  always_ff @(posedge clk) begin
    key_s <= key_s_next;
    key_e <= key_e_next;
    if (o_load) begin
      o_pair <= se_rdata;
      o_mark <= mk_rdata;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    count_next = count; ovf_next = ovf; i_idx_next = i_idx; j_idx_next = j_idx;
    key_s_next = key_s; key_e_next = key_e; groups_next = groups;
    open_grp_next = open_grp;
    se_we = 1'b0; se_waddr = i_idx[AW-1:0]; se_wdata = {key_e, key_s};
    se_raddr = i_idx[AW-1:0];
    mk_we = 1'b0; mk_waddr = j_idx[AW-1:0]; mk_wdata = MarkNone; mk_raddr = j_idx[AW-1:0];
    s_axis_tready = 1'b0; m_axis_tvalid = 1'b0; o_load = 1'b0;
    case (state)
      igp_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        se_waddr = count[AW-1:0];
        se_wdata = s_axis_tdata;
        if (s_axis_tvalid) begin
          if (count < CW'(MAX_INTERVALS)) begin
            se_we = 1'b1;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (s_axis_tlast) begin
            i_idx_next = CW'(1);
            state_next = igp_pkg::ST_SORT_RD;
          end
        end
      end
      // Fetch element i as the key to insert
      igp_pkg::ST_SORT_RD: begin
        if (i_idx >= count) begin
          i_idx_next = '0; j_idx_next = '0; groups_next = '0; open_grp_next = 1'b0;
          mk_raddr = '0;
          se_raddr = '0;
          state_next = igp_pkg::ST_GRP_CHK;
        end else begin
          se_raddr = i_idx[AW-1:0];
          j_idx_next = i_idx;
          state_next = igp_pkg::ST_SORT_CMP;
        end
      end
      // Latch key, then read j-1
      igp_pkg::ST_SORT_CMP: begin
        if (j_idx == i_idx) begin
          key_s_next = rd_s; key_e_next = rd_e;
        end
        se_raddr = AW'(j_idx - 1'b1);
        state_next = igp_pkg::ST_SORT_PUT;
      end
      // Shift j-1 up or drop the key at j
      igp_pkg::ST_SORT_PUT: begin
        se_waddr = j_idx[AW-1:0];
        se_we = 1'b1;
        if (j_idx != '0 && igp_pkg::pair_before(key_s, key_e, rd_s, rd_e)) begin
          se_wdata = se_rdata;
          j_idx_next = j_idx - 1'b1;
          if (j_idx == CW'(1)) begin
            se_we = 1'b1;
            state_next = igp_pkg::ST_SORT_PUT;
          end else begin
            se_raddr = AW'(j_idx - 2'd2);
            state_next = igp_pkg::ST_SORT_PUT;
          end
        end else begin
          se_wdata = {key_e, key_s};
          i_idx_next = i_idx + 1'b1;
          state_next = igp_pkg::ST_SORT_RD;
        end
      end
      // Group passes: data of j is present in read ports; decide and step
      igp_pkg::ST_GRP_CHK: begin
        if (j_idx >= count) begin
          if (open_grp) groups_next = groups + 1'b1;
          open_grp_next = 1'b0;
          // find next unassigned from i+1
          j_idx_next = i_idx + 1'b1;
          i_idx_next = i_idx + 1'b1;
          mk_raddr = AW'(i_idx + 1'b1);
          se_raddr = AW'(i_idx + 1'b1);
          if (i_idx + 1'b1 >= count) begin
            i_idx_next = '0;
            mk_raddr = '0; se_raddr = '0;
            state_next = igp_pkg::ST_OUT_WAIT;
          end else begin
            state_next = igp_pkg::ST_GRP_SCAN;
          end
        end else begin
          state_next = igp_pkg::ST_GRP_SCAN;
          if (mk_rdata == MarkNone &&
              (!open_grp || !($signed(key_e) > $signed(rd_s)))) begin
            mk_we = 1'b1; mk_waddr = j_idx[AW-1:0]; mk_wdata = groups;
            key_e_next = rd_e;
            if (!open_grp) i_idx_next = j_idx;
            open_grp_next = 1'b1;
          end
          j_idx_next = j_idx + 1'b1;
          mk_raddr = AW'(j_idx + 1'b1);
          se_raddr = AW'(j_idx + 1'b1);
        end
      end
      // Bubble for read latency
      igp_pkg::ST_GRP_SCAN: begin
        mk_raddr = j_idx[AW-1:0]; se_raddr = j_idx[AW-1:0];
        state_next = igp_pkg::ST_GRP_CHK;
      end
      igp_pkg::ST_OUT_RD: begin
        mk_raddr = i_idx[AW-1:0]; se_raddr = i_idx[AW-1:0];
        state_next = igp_pkg::ST_OUT_WAIT;
      end
      igp_pkg::ST_OUT_WAIT: begin
        o_load = 1'b1;
        state_next = igp_pkg::ST_OUT_HOLD;
      end
      // Present result and advance on acceptance
      igp_pkg::ST_OUT_HOLD: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          i_idx_next = i_idx + 1'b1;
          if (i_idx + 1'b1 >= count) begin
            j_idx_next = '0;
            state_next = igp_pkg::ST_CLEAR;
          end else begin
            state_next = igp_pkg::ST_OUT_RD;
          end
        end
      end
      // Sweep marks back to unassigned
      igp_pkg::ST_CLEAR: begin
        mk_we = 1'b1; mk_waddr = j_idx[AW-1:0]; mk_wdata = MarkNone;
        j_idx_next = j_idx + 1'b1;
        if (j_idx == CW'(MAX_INTERVALS - 1)) begin
          count_next = '0; ovf_next = 1'b0; i_idx_next = '0; j_idx_next = '0;
          state_next = igp_pkg::ST_LOAD;
        end
      end
      default: state_next = igp_pkg::ST_CLEAR;
    endcase
  end

  assign m_axis_tdata = {2'b0, ovf, groups, o_mark[igp_pkg::GrpW-1:0], o_pair};
  assign m_axis_tlast = (i_idx + 1'b1 == count);

  `IGP_ASSERT_SAME(a_cnt_range, clk, rst, 1'b1, count <= CW'(MAX_INTERVALS))
  `IGP_ASSERT_SAME(a_out_has_items, clk, rst, m_axis_tvalid, count != '0)
  `IGP_ASSERT_NEXT(a_load_after_clear, clk, rst,
                   state == igp_pkg::ST_CLEAR && j_idx == CW'(MAX_INTERVALS - 1),
                   count == '0 && !ovf)
endmodule

FILE: verif/tb_interval_group_partitioner.sv
// Testbench for the interval group partitioner: stream stimulus, greedy partition predictor.
module tb_interval_group_partitioner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = igp_pkg::MaxIntervals;

  typedef struct packed {
    logic [31:0] start_t;
    logic [31:0] end_t;
    logic        last;
  } interval_t;

  typedef struct packed {
    logic [31:0] start_t;
    logic [31:0] end_t;
    logic [5:0]  grp;
    logic [6:0]  total;
    logic        ovf;
    logic        last;
  } group_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // start_time, end_time
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // sorted_start, sorted_end, group_number, group_total, overflowed
  logic        m_axis_tlast;   // last_result

  interval_group_partitioner i_dut (.*);

  // Predictor state: the set being loaded
  logic [31:0] set_start[Cap];
  logic [31:0] set_end[Cap];
  int          set_count;
  bit          set_ovf;
  group_row_t  pending_rows[$];
  int          errors;
  bit          quiet;      // no random idling on either side while set
  bit          hold_done;
  bit          drive_done;

  // Store one accepted interval; on the last one, sort, partition, queue rows
  function automatic void take_interval(interval_t it);
    logic [31:0] s, e;
    int marks[Cap];
    int j, latest, groups;
    group_row_t r;
    if (set_count < Cap) begin
      set_start[set_count] = it.start_t;
      set_end[set_count] = it.end_t;
      set_count++;
    end else begin
      set_ovf = 1;
    end
    if (!it.last) return;
    // insertion sort by start, then end, signed
    for (int i = 1; i < set_count; i++) begin
      s = set_start[i];
      e = set_end[i];
      j = i;
      while (j > 0 && ($signed(s) < $signed(set_start[j-1]) ||
             (s == set_start[j-1] && $signed(e) < $signed(set_end[j-1])))) begin
        set_start[j] = set_start[j-1];
        set_end[j] = set_end[j-1];
        j--;
      end
      set_start[j] = s;
      set_end[j] = e;
    end
    // greedy passes
    groups = 0;
    for (int i = 0; i < Cap; i++) marks[i] = -1;
    for (int i = 0; i < set_count; i++) begin
      if (marks[i] >= 0) continue;
      marks[i] = groups;
      latest = i;
      for (int k = i + 1; k < set_count; k++) begin
        if (marks[k] >= 0) continue;
        if ($signed(set_end[latest]) > $signed(set_start[k])) continue;
        marks[k] = groups;
        latest = k;
      end
      groups++;
    end
    for (int i = 0; i < set_count; i++) begin
      r.start_t = set_start[i];
      r.end_t = set_end[i];
      r.grp = marks[i][5:0];
      r.total = groups[6:0];
      r.ovf = set_ovf;
      r.last = (i == set_count - 1);
      pending_rows = {pending_rows, r};
    end
    set_count = 0;
    set_ovf = 0;
  endfunction

  // Offer one interval, wait for acceptance
  task automatic send_interval(logic [31:0] s, logic [31:0] e, logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {e, s};
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
    take_interval('{s, e, l});
  endtask

  // Random set: narrow values to force overlaps, or full range
  task automatic send_set(int n, bit wide);
    logic [31:0] s, e;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        s = $urandom;
        e = $urandom;
      end else begin
        s = $urandom_range(0, 40) - 20;
        e = ($urandom_range(0, 7) == 0) ? s - $urandom_range(1, 5) : s + $urandom_range(0, 12);
      end
      send_interval(s, e, i == n - 1);
    end
  endtask

  // Directed table: extremes, touching, equal starts, reversed ends
  interval_t directed[] = '{
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
    '{32'd10, 32'd20, 1'b0}, '{32'd20, 32'd30, 1'b0}, '{32'd0, 32'd10, 1'b1},
    '{32'd5, 32'd9, 1'b0}, '{32'd5, 32'd7, 1'b0}, '{32'd5, 32'd7, 1'b0},
    '{32'hFFFF_FFFB, 32'd6, 1'b1},
    '{32'd9, 32'd3, 1'b0}, '{32'd3, 32'd9, 1'b0}, '{32'd4, 32'd8, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}, '{32'h8000_0000, 32'h8000_0000, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sender
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    set_count = 0;
    set_ovf = 0;
    errors = 0;
    quiet = 0;
    drive_done = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_interval(directed[i].start_t, directed[i].end_t, directed[i].last);
    // full store plus two dropped, the second dropped one carrying the last flag
    send_set(Cap + 2, 1'b0);
    send_set(Cap, 1'b1);
    while (pending_rows.size() + set_count < 5 || 1) begin
      if (drive_done) break;
      for (int k = 0; k < 10; k++) begin
        quiet = ($urandom_range(0, 4) == 0);
        send_set($urandom_range(1, 6), $urandom_range(0, 3) == 0);
      end
      drive_done = 1;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
  end

  // Receiver: random stalls, one long hold-off while a big set drains
  initial begin
    group_row_t want, got;
    int stall;
    m_axis_tready = 1'b0;
    hold_done = 0;
    @(negedge rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 18);
      if (!hold_done && pending_rows.size() > 40) begin
        stall = 600;
        hold_done = 1;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[69:64],
              m_axis_tdata[76:70], m_axis_tdata[77], m_axis_tlast};
      if (pending_rows.size() == 0) begin
        $display("%0t: result exp none got %h", $time, got);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (got.start_t !== want.start_t) begin
          $display("%0t: sorted_start exp %h got %h", $time, want.start_t, got.start_t);
          errors++;
        end
        if (got.end_t !== want.end_t) begin
          $display("%0t: sorted_end exp %h got %h", $time, want.end_t, got.end_t);
          errors++;
        end
        if (got.grp !== want.grp) begin
          $display("%0t: group_number exp %0d got %0d", $time, want.grp, got.grp);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: group_total exp %0d got %0d", $time, want.total, got.total);
          errors++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: overflowed exp %b got %b", $time, want.ovf, got.ovf);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_result exp %b got %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Drain, settle, report
  initial begin
    wait (drive_done);
    wait (pending_rows.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
